@@ hdl/adq_pkg.sv @@
package adq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned CountWidth = 8;

  typedef struct packed {
    action_e                       action;
    logic signed [FieldWidth-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0]  popped_value;
    logic        [CountWidth-1:0]  count;
    status_e                       status;
  } rsp_t;

endpackage

@@ hdl/adq_ram.sv @@
module adq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/adq_ctrl.sv @@
module adq_ctrl import adq_pkg::*; #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  req_t                     req_i,
  output logic                     mem_en_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_addr_o,
  output logic [WORD_WIDTH-1:0]    mem_wdata_o,
  input  logic [WORD_WIDTH-1:0]    mem_rdata_i,
  output logic                     done_o,
  output rsp_t                     result_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(DEPTH);
  localparam logic [PtrW-1:0] LastP  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q, pop_ok_q, pop_ok_d;
  status_e         status_q, status_d;

  logic            full, empty;
  logic [PtrW-1:0] head_dec, head_inc, tail_slot, last_slot;
  logic [SumW-1:0] tail_sum, last_sum;
  logic signed [63:0] wide_in, wide_out;

  assign full     = (count_q == DepthC);
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? LastP : head_q - 1'b1;
  assign head_inc = (head_q == LastP) ? '0 : head_q + 1'b1;
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign last_sum = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= DepthS) ? PtrW'(tail_sum - DepthS) : PtrW'(tail_sum);
  assign last_slot = (last_sum >= DepthS) ? PtrW'(last_sum - DepthS) : PtrW'(last_sum);

  assign wide_in     = 64'(req_i.value);
  assign mem_wdata_o = wide_in[WORD_WIDTH-1:0];

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    pop_ok_d   = 1'b0;
    status_d   = ST_DONE;
    mem_en_o   = 1'b0;
    mem_we_o   = 1'b0;
    mem_addr_o = head_q;
    if (accept_i) begin
      unique case (req_i.action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_en_o   = 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = head_dec;
            head_d     = head_dec;
            count_d    = count_q + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_en_o   = 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = tail_slot;
            count_d    = count_q + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            mem_en_o   = 1'b1;
            mem_addr_o = head_q;
            head_d     = head_inc;
            count_d    = count_q - 1'b1;
            pop_ok_d   = 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            mem_en_o   = 1'b1;
            mem_addr_o = last_slot;
            count_d    = count_q - 1'b1;
            pop_ok_d   = 1'b1;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_ok_q <= pop_ok_d;
    status_q <= status_d;
  end

  // read data lands in the cycle after the pop; count_q already holds the new count
  assign wide_out = 64'($signed(mem_rdata_i));

  assign done_o                = done_q;
  assign result_o.popped_value = pop_ok_q ? wide_out[FieldWidth-1:0] : '0;
  assign result_o.count        = CountWidth'(count_q);
  assign result_o.status       = status_q;

endmodule

@@ hdl/array_deque_push_pop.sv @@
// A result strobes on done_o in the cycle after its item is accepted.
// Throughput: one item per cycle; busy_o stays low, since each item makes a
// single access to the word RAM (one port) and the pointer update is local.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset (rst_ni, async active low) empties the queue; RAM contents are kept.
module array_deque_push_pop import adq_pkg::*; #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t result_o
);

  logic                     accept;
  logic                     mem_en, mem_we;
  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic [WORD_WIDTH-1:0]    mem_wdata, mem_rdata;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  adq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  adq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hdl/adq_checker.sv @@
module adq_checker import adq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic done_o,
  input rsp_t result_o
);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without an accepted item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == ST_DONE || result_o.status == ST_FULL ||
                result_o.status == ST_EMPTY))
    else $error("illegal status code");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_DONE) |-> (result_o.popped_value == '0))
    else $error("rejected item returned a word");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |-> (result_o.count == '0))
    else $error("empty status with nonzero count");

endmodule

bind array_deque_push_pop adq_checker u_adq_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import adq_pkg::*;

  localparam int unsigned QDepth = 128;
  localparam int unsigned MaxReports = 50;

  class deque_tracker;
    logic signed [FieldWidth-1:0] shadow_words[$];
    rsp_t pending_results[$];
    int unsigned errors = 0;

    function void record_action(req_t r);
      rsp_t e;
      e.popped_value = '0;
      e.status = ST_DONE;
      case (r.action)
        ACT_PUSH_FRONT: begin
          if (shadow_words.size() >= QDepth) e.status = ST_FULL;
          else shadow_words.push_front(r.value);
        end
        ACT_PUSH_BACK: begin
          if (shadow_words.size() >= QDepth) e.status = ST_FULL;
          else shadow_words.push_back(r.value);
        end
        ACT_POP_FRONT: begin
          if (shadow_words.size() == 0) e.status = ST_EMPTY;
          else e.popped_value = shadow_words.pop_front();
        end
        default: begin
          if (shadow_words.size() == 0) e.status = ST_EMPTY;
          else e.popped_value = shadow_words.pop_back();
        end
      endcase
      e.count = CountWidth'(shadow_words.size());
      pending_results.push_back(e);
    endfunction

    function void report(string field, logic [FieldWidth-1:0] want,
                         logic [FieldWidth-1:0] got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result expected none got %0h", $time, got);
        return;
      end
      e = pending_results.pop_front();
      if (got.popped_value !== e.popped_value)
        report("popped_value", e.popped_value, got.popped_value);
      if (got.count !== e.count) report("count", e.count, got.count);
      if (got.status !== e.status) report("status", e.status, got.status);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t result_o;

  deque_tracker tracker;
  bit idle_on;

  array_deque_push_pop uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && tracker != null) begin
      if (done_o) tracker.check_result(result_o);
      if (start_i && !busy_o) tracker.record_action(req_i);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (!idle_on || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FieldWidth-1:0] rand_word();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return 32'h8000_0000;
    if (p < 16) return 32'h7fff_ffff;
    if (p < 20) return 32'h0000_0000;
    if (p < 24) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic send_item(action_e act, logic [FieldWidth-1:0] word);
    int unsigned gap;
    req_t r;
    gap = gap_len();
    r.action = act;
    r.value = word;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_items, int unsigned push_pct);
    action_e act;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < push_pct)
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else
        act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      send_item(act, rand_word());
    end
  endtask

  initial begin
    int unsigned push_bias[6] = '{97, 8, 50, 95, 3, 70};
    int unsigned sent;
    int unsigned n;
    int unsigned phase;

    tracker = new();
    idle_on = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(ACT_POP_FRONT, 32'h1234_5678);
    send_item(ACT_POP_BACK, 32'hffff_ffff);
    send_item(ACT_PUSH_FRONT, 32'h8000_0000);
    send_item(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_item(ACT_PUSH_FRONT, 32'h0000_0000);
    send_item(ACT_PUSH_BACK, 32'hffff_ffff);
    send_item(ACT_PUSH_FRONT, 32'h5555_5555);
    send_item(ACT_PUSH_BACK, 32'haaaa_aaaa);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_PUSH_BACK, 32'h0000_0001);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);

    sent = 0;
    phase = 0;
    while (sent < 1000) begin
      idle_on = ($urandom_range(0, 2) != 0);
      n = $urandom_range(150, 220);
      run_phase(n, push_bias[phase % 6]);
      sent += n;
      phase++;
    end

    start_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (tracker.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
